### src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the section timing statistics table.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int TS_W       = 64;
	localparam int CNT_W      = 32;
	localparam int IN_KEY_W   = 16;
	localparam int SLOT_OUT_W = 5;
	localparam int S_DATA_W   = 80;   // section_key + timestamp
	localparam int M_DATA_W   = 360;  // 357 bits of fields, padded to bytes

	localparam logic [TS_W-1:0]  MAXINT64  = '1;
	localparam logic [CNT_W-1:0] CNT_LIMIT = '1;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_END   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_UPD
	} state_t;

	typedef struct packed {
		logic accept;   // latch the input beat
		logic lookup;   // key match and stats read
		logic update;   // read-modify-write and result load
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free; // output register can take a result this cycle
	} dp_stat_t;

	typedef struct packed {
		logic [TS_W-1:0]  start;
		logic [TS_W-1:0]  total;
		logic [CNT_W-1:0] count;
		logic [TS_W-1:0]  min0;
		logic [TS_W-1:0]  min1;
		logic [TS_W-1:0]  max0;
		logic [TS_W-1:0]  max1;
	} stat_rec_t;

	// first member listed last: slot sits in the low bits
	typedef struct packed {
		logic [2:0]            pad;
		logic [TS_W-1:0]       max1;
		logic [TS_W-1:0]       max0;
		logic [TS_W-1:0]       min1;
		logic [TS_W-1:0]       min0;
		logic [CNT_W-1:0]      count;
		logic [TS_W-1:0]       total;
		logic [SLOT_OUT_W-1:0] slot;
	} result_t;

	function automatic stat_rec_t empty_rec();
		stat_rec_t r;
		r.start = '0;
		r.total = '0;
		r.count = '0;
		r.min0  = MAXINT64;
		r.min1  = MAXINT64;
		r.max0  = '0;
		r.max1  = '0;
		return r;
	endfunction

endpackage

### src/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: accept, lookup, update. Overlaps the next accept with update.
// ----------------------------------------------------------------------------
module stt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  stt_pkg::dp_stat_t   stat,
	output stt_pkg::ctrl_cmd_t  cmd
);
	import stt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = S_UPD;
			end
			S_UPD: begin
				// hold here while the previous result is still unclaimed
				if (stat.out_free) begin
					cmd.update    = 1'b1;
					s_axis_tready = 1'b1;
					if (s_axis_tvalid) begin
						cmd.accept = 1'b1;
						state_d    = S_LOOK;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### src/stt_keys.sv
// ----------------------------------------------------------------------------
// stt_keys
// Key registers with a fill count. Slots fill in order, so a slot is in use
// when its index is below the count. Keys in use are unique: one-hot match.
// ----------------------------------------------------------------------------
module stt_keys #(
	parameter int SLOTS = 32,
	parameter int KW    = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [KW-1:0]              key,
	input  logic                       insert,
	input  logic                       clear,
	output logic                       hit,
	output logic [$clog2(SLOTS)-1:0]   hit_idx,
	output logic                       full,
	output logic [$clog2(SLOTS)-1:0]   free_idx
);
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [CW-1:0] fill_q;
	logic [KW-1:0] slot_key_q [SLOTS];
	logic [SLOTS-1:0] match;

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (CW'(i) < fill_q) && (slot_key_q[i] == key);
			if (match[i]) begin
				hit_idx = hit_idx | IW'(i);
			end
		end
		hit = |match;
	end

	assign full     = (fill_q == CW'(SLOTS));
	assign free_idx = fill_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear) begin
			fill_q <= '0;
		end else if (insert) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			slot_key_q[fill_q[IW-1:0]] <= key;
		end
	end

endmodule

### src/stt_dp.sv
// ----------------------------------------------------------------------------
// stt_dp
// Datapath: input register, key match, per-slot stats memory with
// read-modify-write, and the output register.
// ----------------------------------------------------------------------------
module stt_dp #(
	parameter int SLOTS    = 32,
	parameter int KEY_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  stt_pkg::ctrl_cmd_t             cmd,
	output stt_pkg::dp_stat_t              stat,
	input  logic [stt_pkg::S_DATA_W-1:0]   s_axis_tdata,
	input  logic [1:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [stt_pkg::M_DATA_W-1:0]   m_axis_tdata,
	output logic [1:0]                     m_axis_tuser
);
	import stt_pkg::*;

	localparam int KW = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
	localparam int IW = $clog2(SLOTS);

	// input beat
	action_t         action_q;
	logic [KW-1:0]   key_q;
	logic [TS_W-1:0] ts_q;

	// lookup
	logic          hit;
	logic          full;
	logic [IW-1:0] hit_idx;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] rd_slot;
	logic          insert;
	logic          clear;

	logic          hit_s1;
	logic          full_s1;
	logic [IW-1:0] slot_s1;
	stat_rec_t     rd_s1;

	stat_rec_t     mem_q [SLOTS];

	// update
	stat_rec_t       base;
	stat_rec_t       upd;
	logic [TS_W-1:0] dur;
	logic [TS_W-1:0] swap;
	logic            ok;
	logic            wr_en;
	status_t         res_sts;
	result_t         res;

	logic            out_valid_q;
	result_t         out_q;
	status_t         out_sts_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= action_t'(s_axis_tuser);
			key_q    <= s_axis_tdata[KW-1:0];
			ts_q     <= s_axis_tdata[IN_KEY_W +: TS_W];
		end
	end

	assign insert = cmd.update && (action_q == ACT_BEGIN) && !hit_s1 && !full_s1;
	assign clear  = cmd.update && (action_q == ACT_CLEAR);

	stt_keys #(
		.SLOTS (SLOTS),
		.KW    (KW)
	) u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_q),
		.insert   (insert),
		.clear    (clear),
		.hit      (hit),
		.hit_idx  (hit_idx),
		.full     (full),
		.free_idx (free_idx)
	);

	assign rd_slot = ((action_q == ACT_BEGIN) && !hit) ? free_idx : hit_idx;

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s1  <= hit;
			full_s1 <= full;
			slot_s1 <= rd_slot;
			rd_s1   <= mem_q[rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[slot_s1] <= upd;
		end
	end

	always_comb begin
		// a freshly taken slot starts from the empty record, not stale memory
		base  = ((action_q == ACT_BEGIN) && !hit_s1) ? empty_rec() : rd_s1;
		dur   = ts_q - base.start;
		upd   = base;
		swap  = '0;
		ok    = hit_s1;
		wr_en = 1'b0;
		res_sts = STS_NOT_FOUND;
		case (action_q)
			ACT_BEGIN: begin
				ok        = hit_s1 || !full_s1;
				res_sts   = ok ? STS_OK : STS_FULL;
				upd.start = ts_q;
				wr_en     = cmd.update && ok;
			end
			ACT_END: begin
				res_sts   = ok ? STS_OK : STS_NOT_FOUND;
				upd.total = base.total + dur;
				if (base.count != CNT_LIMIT) begin
					upd.count = base.count + 1'b1;
				end
				if (base.min1 > dur) begin
					upd.min1 = dur;
				end
				if (base.max1 < dur) begin
					upd.max1 = dur;
				end
				if (upd.max0 < upd.max1) begin
					swap     = upd.max0;
					upd.max0 = upd.max1;
					upd.max1 = swap;
				end
				if (upd.min0 > upd.min1) begin
					swap     = upd.min0;
					upd.min0 = upd.min1;
					upd.min1 = swap;
				end
				wr_en = cmd.update && ok;
			end
			ACT_READ: begin
				res_sts = ok ? STS_OK : STS_NOT_FOUND;
			end
			ACT_CLEAR: begin
				ok      = 1'b1;
				res_sts = STS_OK;
				upd     = empty_rec();
			end
			default: begin
				ok = 1'b0;
			end
		endcase

		res = '0;
		if (ok) begin
			res.slot  = (action_q == ACT_CLEAR) ? '0 : SLOT_OUT_W'(slot_s1);
			res.total = upd.total;
			res.count = upd.count;
			res.min0  = upd.min0;
			res.min1  = upd.min1;
			res.max0  = upd.max0;
			res.max1  = upd.max1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_q     <= res;
			out_sts_q <= res_sts;
		end
	end

	assign stat.out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tuser  = out_sts_q;

endmodule

### src/section_timing_stats_table.sv
// ----------------------------------------------------------------------------
// section_timing_stats_table
// Table of timed sections keyed by id: begin/end timing, totals, call
// counts, two smallest and two largest durations per section.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one beat per event. tuser is the action (begin,
// end, read, clear); tdata carries the section key and the timestamp.
// Output stream (m_axis): exactly one result beat per input beat, in order.
// tuser is the status (ok, full, not found); tdata carries the slot and
// the slot's statistics after the event.
// Each event passes the input register, the lookup (parallel key match and
// stats memory read) and the update (read-modify-write on the single-port
// stats memory, result into the output register). The next event is taken
// in the update step of the last one, when both sides keep up.
// Reset empties the table at once (fill count cleared); no clearing pass.
// When the receiver stalls, the result waits in the output register, the
// block holds the next event after its lookup, before its update, and takes
// no further input beats until the waiting result is taken.
// ----------------------------------------------------------------------------
module section_timing_stats_table #(
	parameter int SLOTS    = 32,
	parameter int KEY_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// section_key[15:0], timestamp[79:16]
	input  logic [stt_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// action[1:0]
	input  logic [1:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// slot[4:0], total_time[68:5], call_count[100:69], min_time[164:101],
	// second_min_time[228:165], max_time[292:229], second_max_time[356:293]
	output logic [stt_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// status[1:0]
	output logic [1:0]                    m_axis_tuser
);
	import stt_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	stt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	stt_dp #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

### tb/section_timing_stats_table_tb.sv
// ----------------------------------------------------------------------------
// section_timing_stats_table_tb
// Self-checking bench for the section timing statistics table. A directed
// table covers empty-table lookups, key extremes, restart of a known key,
// wrapped durations, min/max ordering and clear. A random part follows in
// four flow-control phases. Every result beat is checked field by field
// against a directed row's fixed answer or an in-bench model of the slot table.
// ----------------------------------------------------------------------------
module section_timing_stats_table_tb;
	import stt_pkg::*;

	localparam int NUM_SLOTS   = 32;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 358;

	typedef struct packed {
		status_t          status;
		logic [4:0]       slot;
		logic [TS_W-1:0]  total;
		logic [CNT_W-1:0] calls;
		logic [TS_W-1:0]  min0;
		logic [TS_W-1:0]  min1;
		logic [TS_W-1:0]  max0;
		logic [TS_W-1:0]  max1;
	} section_report_t;

	// known answer for a directed row: status and slot, stats empty or zero
	typedef struct packed {
		bit         typed;
		status_t    status;
		logic [4:0] slot;
	} fixed_answer_t;

	typedef struct packed {
		action_t         act;
		logic [15:0]     key;
		logic [TS_W-1:0] ts;
		bit              typed;
		status_t         status;
		logic [4:0]      slot;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_DATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]           s_axis_tuser = ACT_BEGIN;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_axis_tdata;
	logic [1:0]           m_axis_tuser;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	section_report_t expected_reports[$];
	fixed_answer_t   fixed_answers[$];

	// model of the slot table
	bit               sec_used[NUM_SLOTS];
	logic [15:0]      sec_key[NUM_SLOTS];
	logic [TS_W-1:0]  sec_start[NUM_SLOTS];
	logic [TS_W-1:0]  sec_total[NUM_SLOTS];
	logic [CNT_W-1:0] sec_calls[NUM_SLOTS];
	logic [TS_W-1:0]  sec_min0[NUM_SLOTS];
	logic [TS_W-1:0]  sec_min1[NUM_SLOTS];
	logic [TS_W-1:0]  sec_max0[NUM_SLOTS];
	logic [TS_W-1:0]  sec_max1[NUM_SLOTS];

	section_timing_stats_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void empty_sections();
		for (int i = 0; i < NUM_SLOTS; i++) begin
			sec_used[i]  = 1'b0;
			sec_key[i]   = '0;
			sec_start[i] = '0;
			sec_total[i] = '0;
			sec_calls[i] = '0;
			sec_min0[i]  = MAXINT64;
			sec_min1[i]  = MAXINT64;
			sec_max0[i]  = '0;
			sec_max1[i]  = '0;
		end
	endfunction

	// applies one event to the table model and returns the result beat
	function automatic section_report_t time_section(action_t act, logic [15:0] key,
			logic [TS_W-1:0] ts);
		section_report_t r;
		int hit;
		int free_slot;
		logic [TS_W-1:0] d;
		logic [TS_W-1:0] t;
		r = '0;
		hit = -1;
		free_slot = -1;
		if (act == ACT_CLEAR) begin
			empty_sections();
		end else begin
			// slots fill in order: stop at the first free one or the first match
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (hit < 0 && free_slot < 0) begin
					if (!sec_used[i])
						free_slot = i;
					else if (sec_key[i] == key)
						hit = i;
				end
			end
			if (act == ACT_BEGIN) begin
				if (hit < 0 && free_slot < 0) begin
					r.status = STS_FULL;
					return r;
				end
				if (hit < 0) begin
					hit = free_slot;
					sec_used[hit] = 1'b1;
					sec_key[hit] = key;
				end
				sec_start[hit] = ts;
			end else begin
				if (hit < 0) begin
					r.status = STS_NOT_FOUND;
					return r;
				end
				if (act == ACT_END) begin
					d = ts - sec_start[hit];
					sec_total[hit] = sec_total[hit] + d;
					if (sec_calls[hit] != CNT_LIMIT)
						sec_calls[hit] = sec_calls[hit] + 1'b1;
					if (sec_min1[hit] > d)
						sec_min1[hit] = d;
					if (sec_max1[hit] < d)
						sec_max1[hit] = d;
					if (sec_max0[hit] < sec_max1[hit]) begin
						t = sec_max0[hit];
						sec_max0[hit] = sec_max1[hit];
						sec_max1[hit] = t;
					end
					if (sec_min0[hit] > sec_min1[hit]) begin
						t = sec_min0[hit];
						sec_min0[hit] = sec_min1[hit];
						sec_min1[hit] = t;
					end
				end
			end
		end
		if (hit < 0)
			hit = 0;
		r.status = STS_OK;
		r.slot   = hit[4:0];
		r.total  = sec_total[hit];
		r.calls  = sec_calls[hit];
		r.min0   = sec_min0[hit];
		r.min1   = sec_min1[hit];
		r.max0   = sec_max0[hit];
		r.max1   = sec_max1[hit];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [TS_W-1:0] got, logic [TS_W-1:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_report(section_report_t want, logic [1:0] sts, result_t got);
		if (sts !== want.status)
			report_mismatch("status", 64'(sts), 64'(want.status));
		if (got.slot !== want.slot)
			report_mismatch("slot", 64'(got.slot), 64'(want.slot));
		if (got.total !== want.total)
			report_mismatch("total_time", got.total, want.total);
		if (got.count !== want.calls)
			report_mismatch("call_count", 64'(got.count), 64'(want.calls));
		if (got.min0 !== want.min0)
			report_mismatch("min_time", got.min0, want.min0);
		if (got.min1 !== want.min1)
			report_mismatch("second_min_time", got.min1, want.min1);
		if (got.max0 !== want.max0)
			report_mismatch("max_time", got.max0, want.max0);
		if (got.max1 !== want.max1)
			report_mismatch("second_max_time", got.max1, want.max1);
	endtask

	// called just after a falling edge; returns just after the falling edge
	// that follows the accepting rising edge
	task automatic drive_event(action_t act, logic [15:0] key, logic [TS_W-1:0] ts,
			fixed_answer_t answer);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		fixed_answers.push_back(answer);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {ts, key};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	always @(posedge clk) begin : monitor
		section_report_t want;
		fixed_answer_t answer;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = time_section(action_t'(s_axis_tuser), s_axis_tdata[15:0],
					s_axis_tdata[S_DATA_W-1:16]);
				answer = fixed_answers.pop_front();
				if (answer.typed) begin
					want = '0;
					want.status = answer.status;
					want.slot = answer.slot;
					if (answer.status == STS_OK) begin
						want.min0 = MAXINT64;
						want.min1 = MAXINT64;
					end
				end
				expected_reports.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reports.size() == 0)
					report_mismatch("result beat with nothing pending", '0, '0);
				else
					check_report(expected_reports.pop_front(), m_axis_tuser,
						result_t'(m_axis_tdata));
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		plan_row_t plan[22];
		int src_pct[4];
		int sink_pct[4];
		int pool_sizes[3];
		int pool_n;
		int pick;
		logic [15:0] pool_base;
		logic [15:0] key;
		logic [TS_W-1:0] now;
		logic [TS_W-1:0] ts;
		action_t act;

		plan = '{
			'{ACT_READ,  16'h0000, 64'd0,                 1'b1, STS_NOT_FOUND, 5'd0},
			'{ACT_END,   16'hFFFF, 64'd0,                 1'b1, STS_NOT_FOUND, 5'd0},
			'{ACT_BEGIN, 16'h0000, 64'd0,                 1'b1, STS_OK,        5'd0},
			'{ACT_BEGIN, 16'hFFFF, MAXINT64,              1'b1, STS_OK,        5'd1},
			'{ACT_END,   16'h0000, 64'd100,               1'b0, STS_OK,        5'd0},
			'{ACT_END,   16'hFFFF, 64'd5,                 1'b0, STS_OK,        5'd0},
			'{ACT_BEGIN, 16'h0000, 64'd1000,              1'b0, STS_OK,        5'd0},
			'{ACT_END,   16'h0000, 64'd1050,              1'b0, STS_OK,        5'd0},
			'{ACT_END,   16'h0000, 64'd1010,              1'b0, STS_OK,        5'd0},
			'{ACT_END,   16'h0000, 64'd1300,              1'b0, STS_OK,        5'd0},
			'{ACT_END,   16'h0000, 64'd1000,              1'b0, STS_OK,        5'd0},
			'{ACT_END,   16'h0000, 64'd999,               1'b0, STS_OK,        5'd0},
			'{ACT_READ,  16'h0000, 64'd0,                 1'b0, STS_OK,        5'd0},
			'{ACT_BEGIN, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, STS_OK,      5'd2},
			'{ACT_END,   16'h5555, MAXINT64,              1'b0, STS_OK,        5'd0},
			'{ACT_BEGIN, 16'hAAAA, 64'h5555_5555_5555_5555, 1'b1, STS_OK,      5'd3},
			'{ACT_READ,  16'h1234, 64'd0,                 1'b1, STS_NOT_FOUND, 5'd0},
			'{ACT_CLEAR, 16'h0000, 64'd0,                 1'b1, STS_OK,        5'd0},
			'{ACT_READ,  16'h0000, 64'd0,                 1'b1, STS_NOT_FOUND, 5'd0},
			'{ACT_END,   16'h0000, 64'd7,                 1'b1, STS_NOT_FOUND, 5'd0},
			'{ACT_BEGIN, 16'h0007, 64'd3,                 1'b1, STS_OK,        5'd0},
			'{ACT_READ,  16'h0007, MAXINT64,              1'b1, STS_OK,        5'd0}
		};
		src_pct    = '{0, 68, 0, 11};
		sink_pct   = '{0, 0, 68, 11};
		pool_sizes = '{4, 40, 48};

		empty_sections();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			drive_event(plan[i].act, plan[i].key, plan[i].ts,
				'{plan[i].typed, plan[i].status, plan[i].slot});

		// mostly a drifting clock over a key pool; pools of 40+ fill the table
		pool_base = 16'($urandom);
		pool_n = 48;
		now = {$urandom, $urandom};
		for (int p = 0; p < 4; p++) begin
			src_idle_pct = src_pct[p];
			sink_stall_pct = sink_pct[p];
			if (p == 2) begin
				s_axis_tvalid <= 1'b0;
				while (expected_reports.size() != 0)
					@(negedge clk);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 39) == 0)
					now = {$urandom, $urandom};
				else
					now = now + $urandom_range(0, 5000);
				ts = now;
				key = pool_base + 16'($urandom_range(0, pool_n - 1));
				pick = $urandom_range(0, 999);
				if (pick < 5) begin
					act = ACT_CLEAR;
					pool_base = 16'($urandom);
					pool_n = pool_sizes[$urandom_range(0, 2)];
				end else if (pick < 380) begin
					act = ACT_BEGIN;
				end else if (pick < 760) begin
					act = ACT_END;
				end else if (pick < 940) begin
					act = ACT_READ;
				end else begin
					act = action_t'($urandom_range(0, 2));
					key = 16'($urandom);
					ts = {$urandom, $urandom};
				end
				drive_event(act, key, ts, '{1'b0, STS_OK, 5'd0});
			end
		end
		s_axis_tvalid <= 1'b0;

		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
